@@ src/nonlinear_connection_force_step_macros.svh @@
// assertion macros for the connection force block
// used by nonlinear_connection_force_step, expects clk and rst_n in scope
`ifndef NONLINEAR_CONNECTION_FORCE_STEP_MACROS_SVH
`define NONLINEAR_CONNECTION_FORCE_STEP_MACROS_SVH

// same-cycle implication
`define NCFS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NCFS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ncfs_pkg.sv @@
// types, constants and the micro-program of the connection force block
// no dependencies
`default_nettype none
package ncfs_pkg;

  localparam int QW         = 48;
  localparam int MUL_STEPS  = 48;
  localparam int DIV_STEPS  = 80;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [QW-1:0] Q_ONE  = 48'h0001_0000_0000;
  localparam logic [QW-1:0] Q_TWO  = 48'h0002_0000_0000;
  localparam logic [QW-1:0] Q_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [QW-1:0] Q_MIN  = 48'h8000_0000_0000;
  localparam logic [63:0]   M_LIM  = 64'h0000_8000_0000_0000;
  localparam logic [49:0]   Q_CAP  = 50'h1_0000_0000_0000;

  typedef enum logic [2:0] {
    REG_SPACING_A   = 3'd0,
    REG_SPACING_B   = 3'd1,
    REG_GAIN_A      = 3'd2,
    REG_GAIN_B      = 3'd3,
    REG_PHI_MINUS   = 3'd4,
    REG_PHI_PLUS    = 3'd5,
    REG_CUBIC_STIFF = 3'd6,
    REG_MASS_DIFF   = 3'd7
  } reg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DEC  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_MWB  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DWB  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    K_MUL = 3'd0,
    K_ADD = 3'd1,
    K_SUB = 3'd2,
    K_DIV = 3'd3,
    K_END = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    SRC_SA, SRC_SB, SRC_UA, SRC_UB, SRC_NA, SRC_NB, SRC_T0, SRC_T1,
    SRC_ETA, SRC_BN, SRC_CS, SRC_PM, SRC_PP, SRC_R, SRC_P, SRC_PREV,
    SRC_MD, SRC_TWO, SRC_F, SRC_GA, SRC_GB
  } src_t;

  typedef enum logic [2:0] {
    DST_T0, DST_T1, DST_ETA, DST_BN, DST_R, DST_P, DST_F
  } dst_t;

  typedef struct packed {
    kind_t kind;
    src_t  src_a;
    src_t  src_b;
    dst_t  dst;
  } uop_t;

  // the step sequence of one item; the two final forces land in r and p
  function automatic uop_t prog(input logic [4:0] idx);
    uop_t u;
    case (idx)
      5'd0:    u = '{K_MUL, SRC_SA,  SRC_UA,   DST_T0};
      5'd1:    u = '{K_MUL, SRC_SB,  SRC_UB,   DST_T1};
      5'd2:    u = '{K_SUB, SRC_T0,  SRC_T1,   DST_ETA};
      5'd3:    u = '{K_MUL, SRC_SA,  SRC_NA,   DST_T0};
      5'd4:    u = '{K_MUL, SRC_SB,  SRC_NB,   DST_T1};
      5'd5:    u = '{K_SUB, SRC_T0,  SRC_T1,   DST_BN};
      5'd6:    u = '{K_MUL, SRC_ETA, SRC_ETA,  DST_T0};
      5'd7:    u = '{K_MUL, SRC_CS,  SRC_T0,   DST_T1};
      5'd8:    u = '{K_SUB, SRC_PM,  SRC_T1,   DST_R};
      5'd9:    u = '{K_ADD, SRC_PP,  SRC_T1,   DST_P};
      5'd10:   u = '{K_MUL, SRC_R,   SRC_PREV, DST_T0};
      5'd11:   u = '{K_MUL, SRC_BN,  SRC_P,    DST_T1};
      5'd12:   u = '{K_SUB, SRC_T0,  SRC_T1,   DST_T0};
      5'd13:   u = '{K_MUL, SRC_MD,  SRC_P,    DST_T1};
      5'd14:   u = '{K_ADD, SRC_T1,  SRC_TWO,  DST_T1};
      5'd15:   u = '{K_DIV, SRC_T0,  SRC_T1,   DST_F};
      5'd16:   u = '{K_MUL, SRC_GA,  SRC_F,    DST_R};
      5'd17:   u = '{K_MUL, SRC_GB,  SRC_F,    DST_P};
      default: u = '{K_END, SRC_T0,  SRC_T0,   DST_T0};
    endcase
    return u;
  endfunction

  // clamp a 49-bit sum, flag in the top bit
  function automatic logic [QW:0] sat_sum(input logic [QW:0] s);
    logic ovf;
    ovf = s[QW] ^ s[QW-1];
    return {ovf, ovf ? (s[QW] ? Q_MIN : Q_MAX) : s[QW-1:0]};
  endfunction

  // give a magnitude its sign and clamp, flag in the top bit
  function automatic logic [QW:0] sign_mag(input logic [63:0] m, input logic neg);
    logic [63:0]   mc;
    logic          ovf;
    logic [QW-1:0] v;
    if (neg) begin
      ovf = m > M_LIM;
      mc  = ovf ? M_LIM : m;
      v   = QW'(0) - mc[QW-1:0];
    end else begin
      ovf = m > (M_LIM - 64'd1);
      mc  = ovf ? (M_LIM - 64'd1) : m;
      v   = mc[QW-1:0];
    end
    return {ovf, v};
  endfunction

endpackage
`default_nettype wire

@@ src/nonlinear_connection_force_step.sv @@
// nonlinear spring connection force, one audio step per item
// uses ncfs_pkg and nonlinear_connection_force_step_macros.svh
//
//   channel | direction | ports
//   in      | sink      | in_valid, in_ready, in_disp_{a,b}_{now,next}
//   out     | source    | out_valid, out_ready, out_force_on_{a,b}, out_saturated
//   cfg     | apb slave | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// each item runs eleven bit-serial multiplies (48 shift-add steps each, plus decode
// and write-back), one restoring divide unless the divisor is zero, and the adds
// and subtracts; the shared serial multiplier sets the pace.
// reset is synchronous and needs no clearing pass.
// a finished result waits in the output register; the next item is taken while
// it waits, and only the end of the following item stalls on it.
`default_nettype none
`include "nonlinear_connection_force_step_macros.svh"
module nonlinear_connection_force_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [47:0] in_disp_a_now,
  input  logic signed [47:0] in_disp_b_now,
  input  logic signed [47:0] in_disp_a_next,
  input  logic signed [47:0] in_disp_b_next,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_force_on_a,
  output logic signed [47:0] out_force_on_b,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import ncfs_pkg::*;

  logic [QW-1:0] spacing_a_r, spacing_b_r, gain_a_r, gain_b_r;
  logic [QW-1:0] phi_minus_r, phi_plus_r, cubic_r, mass_diff_r;
  logic [QW-1:0] prev_r;
  logic [QW-1:0] ua_r, ub_r, na_r, nb_r;
  logic [QW-1:0] t0_r, t1_r, eta_r, bn_r, r_r, p_r, f_r;

  state_t         state_r;
  logic [4:0]     op_r;
  logic [CNT_W-1:0] cnt_r;
  logic           sat_r;
  logic           out_valid_r;
  logic [QW-1:0]  out_a_r, out_b_r;
  logic           out_sat_r;

  // serial multiplier and divider
  logic [QW-1:0]  ma_r;
  logic [95:0]    prod_r;
  logic           neg_r;
  logic [79:0]    nsh_r;
  logic [QW-1:0]  den_r;
  logic [QW-1:0]  rem_r;
  logic [QW:0]    q_r;
  logic           over_r;

  uop_t           uop;
  logic [QW-1:0]  opa, opb, mag_a, mag_b;
  logic [QW:0]    sum49, sum_res;
  logic [QW:0]    mul_add;
  logic [95:0]    prod_nxt;
  logic [63:0]    mul_q;
  logic [QW:0]    rem_sh, rem_diff;
  logic           div_ge;
  logic [QW-1:0]  rem_nxt;
  logic [49:0]    q_sh;
  logic           q_big;
  logic [QW:0]    q_nxt;
  logic           rnd;
  logic [63:0]    div_q;
  logic           wb_en, wb_flag;
  logic [QW-1:0]  wb_val;
  logic [QW:0]    sm;
  logic           cfg_we;
  logic           end_load;

  function automatic logic [QW-1:0] sel_opnd(input src_t s);
    case (s)
      SRC_SA:   return spacing_a_r;
      SRC_SB:   return spacing_b_r;
      SRC_UA:   return ua_r;
      SRC_UB:   return ub_r;
      SRC_NA:   return na_r;
      SRC_NB:   return nb_r;
      SRC_T0:   return t0_r;
      SRC_T1:   return t1_r;
      SRC_ETA:  return eta_r;
      SRC_BN:   return bn_r;
      SRC_CS:   return cubic_r;
      SRC_PM:   return phi_minus_r;
      SRC_PP:   return phi_plus_r;
      SRC_R:    return r_r;
      SRC_P:    return p_r;
      SRC_PREV: return prev_r;
      SRC_MD:   return mass_diff_r;
      SRC_TWO:  return Q_TWO;
      SRC_F:    return f_r;
      SRC_GA:   return gain_a_r;
      SRC_GB:   return gain_b_r;
      default:  return '0;
    endcase
  endfunction

  assign uop   = prog(op_r);

  // operands are selected combinationally by the current step index
  always_comb begin
    opa = sel_opnd(uop.src_a);
    opb = sel_opnd(uop.src_b);
  end

  assign mag_a = opa[QW-1] ? (QW'(0) - opa) : opa;
  assign mag_b = opb[QW-1] ? (QW'(0) - opb) : opb;

  assign sum49   = (uop.kind == K_SUB) ? ({opa[QW-1], opa} - {opb[QW-1], opb})
                                       : ({opa[QW-1], opa} + {opb[QW-1], opb});
  assign sum_res = sat_sum(sum49);

  // one multiplier bit per cycle, product shifts right
  assign mul_add  = {1'b0, prod_r[95:48]} + (prod_r[0] ? {1'b0, ma_r} : '0);
  assign prod_nxt = {mul_add, prod_r[47:1]};
  assign mul_q    = {1'b0, prod_r[94:32]} + {63'd0, prod_r[31]};

  // one quotient bit per cycle, numerator bits then fraction zeros
  assign rem_sh   = {rem_r, nsh_r[79]};
  assign div_ge   = rem_sh >= {1'b0, den_r};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign rem_nxt  = div_ge ? rem_diff[QW-1:0] : rem_sh[QW-1:0];
  assign q_sh     = {q_r, div_ge};
  assign q_big    = over_r || (q_sh > Q_CAP);
  assign q_nxt    = q_big ? Q_CAP[QW:0] : q_sh[QW:0];
  assign rnd      = !over_r && ({rem_r, 1'b0} >= {1'b0, den_r});
  assign div_q    = {15'd0, q_r} + {63'd0, rnd};

  assign sm = sign_mag((state_r == ST_MWB) ? mul_q : div_q, neg_r);

  always_comb begin
    wb_en   = 1'b0;
    wb_flag = 1'b0;
    wb_val  = sum_res[QW-1:0];
    case (state_r)
      ST_DEC: begin
        if (uop.kind == K_ADD || uop.kind == K_SUB) begin
          wb_en   = 1'b1;
          wb_flag = sum_res[QW];
        end else if (uop.kind == K_DIV && mag_b == '0) begin
          wb_en   = 1'b1;
          wb_flag = 1'b1;
          wb_val  = '0;
        end
      end
      ST_MWB, ST_DWB: begin
        wb_en   = 1'b1;
        wb_flag = sm[QW];
        wb_val  = sm[QW-1:0];
      end
      default: wb_en = 1'b0;
    endcase
  end

  assign end_load = (state_r == ST_DEC) && (uop.kind == K_END) &&
                    (!out_valid_r || out_ready);
  assign cfg_we   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= '0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      spacing_a_r <= Q_ONE;
      spacing_b_r <= Q_ONE;
      gain_a_r    <= '0;
      gain_b_r    <= '0;
      phi_minus_r <= '0;
      phi_plus_r  <= '0;
      cubic_r     <= '0;
      mass_diff_r <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(paddr[5:3]))
          REG_SPACING_A:   spacing_a_r <= pwdata[QW-1:0];
          REG_SPACING_B:   spacing_b_r <= pwdata[QW-1:0];
          REG_GAIN_A:      gain_a_r    <= pwdata[QW-1:0];
          REG_GAIN_B:      gain_b_r    <= pwdata[QW-1:0];
          REG_PHI_MINUS:   phi_minus_r <= pwdata[QW-1:0];
          REG_PHI_PLUS:    phi_plus_r  <= pwdata[QW-1:0];
          REG_CUBIC_STIFF: cubic_r     <= pwdata[QW-1:0];
          REG_MASS_DIFF:   mass_diff_r <= pwdata[QW-1:0];
          default:         spacing_a_r <= spacing_a_r;
        endcase
      end

      if (end_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (wb_en) begin
        sat_r <= sat_r | wb_flag;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sat_r   <= 1'b0;
            op_r    <= '0;
            state_r <= ST_DEC;
          end
        end
        ST_DEC: begin
          case (uop.kind)
            K_MUL: begin
              cnt_r   <= '0;
              state_r <= ST_MUL;
            end
            K_ADD, K_SUB: begin
              op_r <= op_r + 5'd1;
            end
            K_DIV: begin
              if (mag_b == '0) begin
                op_r <= op_r + 5'd1;
              end else begin
                cnt_r   <= '0;
                state_r <= ST_DIV;
              end
            end
            K_END: begin
              if (end_load) begin
                prev_r  <= eta_r;
                op_r    <= '0;
                state_r <= ST_IDLE;
              end
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_MUL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
            state_r <= ST_MWB;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= ST_DWB;
          end
        end
        ST_MWB, ST_DWB: begin
          op_r    <= op_r + 5'd1;
          state_r <= ST_DEC;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      ua_r <= in_disp_a_now;
      ub_r <= in_disp_b_now;
      na_r <= in_disp_a_next;
      nb_r <= in_disp_b_next;
    end

    if (state_r == ST_DEC && uop.kind == K_MUL) begin
      ma_r   <= mag_a;
      prod_r <= {48'd0, mag_b};
      neg_r  <= opa[QW-1] ^ opb[QW-1];
    end else if (state_r == ST_MUL) begin
      prod_r <= prod_nxt;
    end

    if (state_r == ST_DEC && uop.kind == K_DIV) begin
      nsh_r  <= {mag_a, 32'd0};
      den_r  <= mag_b;
      neg_r  <= opa[QW-1] ^ opb[QW-1];
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
    end else if (state_r == ST_DIV) begin
      nsh_r  <= {nsh_r[78:0], 1'b0};
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      over_r <= q_big;
    end

    if (wb_en) begin
      case (uop.dst)
        DST_T0:  t0_r  <= wb_val;
        DST_T1:  t1_r  <= wb_val;
        DST_ETA: eta_r <= wb_val;
        DST_BN:  bn_r  <= wb_val;
        DST_R:   r_r   <= wb_val;
        DST_P:   p_r   <= wb_val;
        DST_F:   f_r   <= wb_val;
        default: t0_r  <= wb_val;
      endcase
    end

    if (end_load) begin
      out_a_r   <= r_r;
      out_b_r   <= p_r;
      out_sat_r <= sat_r;
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[5:3]))
      REG_SPACING_A:   prdata = {{16{spacing_a_r[QW-1]}}, spacing_a_r};
      REG_SPACING_B:   prdata = {{16{spacing_b_r[QW-1]}}, spacing_b_r};
      REG_GAIN_A:      prdata = {{16{gain_a_r[QW-1]}}, gain_a_r};
      REG_GAIN_B:      prdata = {{16{gain_b_r[QW-1]}}, gain_b_r};
      REG_PHI_MINUS:   prdata = {{16{phi_minus_r[QW-1]}}, phi_minus_r};
      REG_PHI_PLUS:    prdata = {{16{phi_plus_r[QW-1]}}, phi_plus_r};
      REG_CUBIC_STIFF: prdata = {{16{cubic_r[QW-1]}}, cubic_r};
      REG_MASS_DIFF:   prdata = {{16{mass_diff_r[QW-1]}}, mass_diff_r};
      default:         prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_force_on_a = out_a_r;
  assign out_force_on_b = out_b_r;
  assign out_saturated  = out_sat_r;

  `NCFS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `NCFS_ASSERT_SAME(a_idle_program_start, state_r == ST_IDLE, op_r == '0, "step index not rewound")
  `NCFS_ASSERT_NEXT(a_end_waits_for_output,
                    state_r == ST_DEC && uop.kind == K_END && out_valid_r && !out_ready,
                    state_r == ST_DEC && out_valid_r, "pending result overwritten")

endmodule
`default_nettype wire

@@ dv/ncfs_checker.sv @@
// scoreboard for the connection force block: watches the config port and both channels
// predicts each result in signed Q16.32 with saturation; depends on ncfs_pkg
`timescale 1ns / 100ps
module ncfs_checker
  import ncfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [47:0] in_disp_a_now,
  input  logic signed [47:0] in_disp_b_now,
  input  logic signed [47:0] in_disp_a_next,
  input  logic signed [47:0] in_disp_b_next,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [47:0] out_force_on_a,
  input  logic signed [47:0] out_force_on_b,
  input  logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output int                 fail_count,
  output int                 forces_pending,
  output int                 forces_seen,
  output int                 sat_seen
);

  localparam longint QMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint QMIN = -64'sh8000_0000_0000;

  typedef struct {
    logic [47:0] fa;
    logic [47:0] fb;
    logic        sat;
  } force_t;

  force_t expected_forces[$];

  longint spc_a, spc_b, gn_a, gn_b, ph_m, ph_p, cub, mdiff, eta_prev;
  logic   clip;

  function automatic longint clampq(longint v);
    if (v > QMAX) begin
      clip = 1'b1;
      return QMAX;
    end
    if (v < QMIN) begin
      clip = 1'b1;
      return QMIN;
    end
    return v;
  endfunction

  function automatic longint signed_mag(logic [127:0] m, logic neg);
    if (neg) begin
      if (m > 128'h8000_0000_0000) begin
        clip = 1'b1;
        m = 128'h8000_0000_0000;
      end
      return -longint'(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF) begin
      clip = 1'b1;
      m = 128'h7FFF_FFFF_FFFF;
    end
    return longint'(m[63:0]);
  endfunction

  function automatic logic [127:0] mag(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint mulq(longint a, longint b);
    logic [127:0] prod;
    prod = mag(a) * mag(b) + 128'h8000_0000;
    return signed_mag(prod >> 32, (a < 0) != (b < 0));
  endfunction

  function automatic longint divq(longint num, longint den);
    logic [127:0] n, d, quo, rem;
    n = mag(num) << 32;
    d = mag(den);
    if (d == 0) begin
      clip = 1'b1;
      return 0;
    end
    quo = n / d;
    rem = n % d;
    if (quo > (128'd1 << 48)) quo = 128'd1 << 48;
    else if (rem >= d - rem) quo = quo + 1;
    return signed_mag(quo, (num < 0) != (den < 0));
  endfunction

  function automatic force_t predict_force(longint ua, longint ub, longint na, longint nb);
    longint eta, bn, w, r, p, num, den, f;
    force_t e;
    clip = 1'b0;
    eta = clampq(mulq(spc_a, ua) - mulq(spc_b, ub));
    bn  = clampq(mulq(spc_a, na) - mulq(spc_b, nb));
    w   = mulq(cub, mulq(eta, eta));
    r   = clampq(ph_m - w);
    p   = clampq(ph_p + w);
    num = clampq(mulq(r, eta_prev) - mulq(bn, p));
    den = clampq(mulq(mdiff, p) + (64'sd1 <<< 33));
    f   = divq(num, den);
    eta_prev = eta;
    e.fa  = 48'(mulq(gn_a, f));
    e.fb  = 48'(mulq(gn_b, f));
    e.sat = clip;
    return e;
  endfunction

  always @(posedge clk) begin
    force_t e;
    longint v;
    if (!rst_n) begin
      spc_a = 64'sd1 <<< 32;
      spc_b = 64'sd1 <<< 32;
      {gn_a, gn_b, ph_m, ph_p, cub, mdiff, eta_prev} = '0;
      expected_forces.delete();
      fail_count = 0;
      forces_seen = 0;
      sat_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        v = longint'($signed(pwdata[47:0]));
        case (reg_idx_t'(paddr[5:3]))
          REG_SPACING_A:   spc_a = v;
          REG_SPACING_B:   spc_b = v;
          REG_GAIN_A:      gn_a  = v;
          REG_GAIN_B:      gn_b  = v;
          REG_PHI_MINUS:   ph_m  = v;
          REG_PHI_PLUS:    ph_p  = v;
          REG_CUBIC_STIFF: cub   = v;
          REG_MASS_DIFF:   mdiff = v;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_forces.insert(expected_forces.size(), predict_force(longint'(in_disp_a_now),
          longint'(in_disp_b_now), longint'(in_disp_a_next), longint'(in_disp_b_next)));
      if (out_valid && out_ready) begin
        forces_seen++;
        if (out_saturated) sat_seen++;
        if (expected_forces.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item: fa=%h fb=%h sat=%b",
            out_force_on_a, out_force_on_b, out_saturated);
        end else begin
          e = expected_forces.pop_front();
          if (out_force_on_a !== e.fa || out_force_on_b !== e.fb || out_saturated !== e.sat)
          begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch on result %0d: exp fa=%h fb=%h sat=%b, got fa=%h fb=%h sat=%b",
                forces_seen, e.fa, e.fb, e.sat,
                out_force_on_a, out_force_on_b, out_saturated);
          end
        end
      end
    end
    forces_pending = expected_forces.size();
  end

endmodule

@@ dv/tb_top.sv @@
// stimulus and verdict for the connection force block
// instantiates nonlinear_connection_force_step and ncfs_checker; uses ncfs_pkg
`timescale 1ns / 100ps
module tb_top;
  import ncfs_pkg::*;

  localparam int     CYCLE_LIMIT = 4_000_000;
  localparam longint QONE = 64'sd1 <<< 32;
  localparam longint QMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint QMIN = -64'sh8000_0000_0000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [47:0] in_disp_a_now = '0, in_disp_b_now = '0;
  logic signed [47:0] in_disp_a_next = '0, in_disp_b_next = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [47:0] out_force_on_a, out_force_on_b;
  logic               out_saturated;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  int  fail_count, forces_pending, forces_seen, sat_seen;
  int  cycles = 0;
  int  stall_left = 0;
  int  items_sent = 0;
  bit  quiet = 1'b0;

  always #6 clk = ~clk;

  nonlinear_connection_force_step DUT (.*);

  ncfs_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls in short bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic longint pick_q(int kind);
    longint v;
    case (kind)
      0: v = longint'({$urandom, $urandom}) >>> 28;
      1: v = longint'($signed(48'({$urandom, $urandom})));
      default: begin
        case ($urandom_range(0, 5))
          0: v = QMAX;
          1: v = QMIN;
          2: v = 0;
          3: v = QONE;
          4: v = -QONE;
          default: v = 1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic longint mixed_q();
    int r;
    r = $urandom_range(0, 9);
    return pick_q(r < 8 ? 0 : (r == 8 ? 1 : 2));
  endfunction

  task automatic set_reg(reg_idx_t idx, longint v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= {16'($urandom), v[47:0]};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_all(longint sa, longint sb, longint ga, longint gb,
                         longint pm, longint pp, longint cs, longint md);
    set_reg(REG_SPACING_A, sa);
    set_reg(REG_SPACING_B, sb);
    set_reg(REG_GAIN_A, ga);
    set_reg(REG_GAIN_B, gb);
    set_reg(REG_PHI_MINUS, pm);
    set_reg(REG_PHI_PLUS, pp);
    set_reg(REG_CUBIC_STIFF, cs);
    set_reg(REG_MASS_DIFF, md);
  endtask

  task automatic send_step(longint ua, longint ub, longint na, longint nb);
    int gap;
    gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_disp_a_now  <= ua[47:0];
    in_disp_b_now  <= ub[47:0];
    in_disp_a_next <= na[47:0];
    in_disp_b_next <= nb[47:0];
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // config changes only once every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (forces_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int kind;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: typical coefficients, field extremes
    set_all(QONE, QONE, QONE, -QONE, QONE / 2, 3 * QONE / 2, QONE / 4, QONE / 2);
    send_step(0, 0, 0, 0);
    send_step(QMAX, QMAX, QMAX, QMAX);
    send_step(QMIN, QMIN, QMIN, QMIN);
    send_step(QMAX, QMIN, QMIN, QMAX);
    send_step(1, -1, -1, 1);
    send_step(QONE, 0, QONE / 2, 0);
    send_step(QONE / 2, -QONE / 4, QONE, QONE);
    send_step(-3 * QONE, 2 * QONE, QONE, -QONE);
    drain();

    // zero divisor: mass term -2 against p = 1
    set_all(QONE, QONE, QONE, QONE, QONE, QONE, 0, -2 * QONE);
    send_step(QONE, 0, QONE, 0);
    send_step(0, QONE, QONE / 2, 0);
    drain();
    set_reg(REG_CUBIC_STIFF, QONE);
    // equal displacements keep eta at zero, so the divisor stays zero
    send_step(QONE, QONE, 2 * QONE, 0);
    drain();

    // register extremes
    set_all(QMAX, QMIN, QMAX, QMIN, QMIN, QMAX, QMAX, QMIN);
    send_step(QONE, -QONE, 1, 0);
    send_step(0, 0, 0, 0);
    send_step(QMIN, QMAX, QONE, QONE);
    drain();
    set_all(QMIN, QMAX, QMIN, QMAX, QMAX, QMIN, QMIN, QMAX);
    send_step(1, 1, -1, -1);
    send_step(QMAX, 0, QMIN, 0);
    drain();

    // random phases, each with its own coefficients
    for (int ph = 0; ph < 8; ph++) begin
      kind = (ph == 2 || ph == 5) ? 2 : (ph == 3 ? 1 : 0);
      if (ph == 7) quiet = 1'b1;
      set_all(pick_q(kind), pick_q(kind), pick_q(kind), pick_q(kind),
              pick_q(kind), pick_q(kind), pick_q(kind), pick_q(kind));
      for (int k = 0; k < 136; k++)
        send_step(mixed_q(), mixed_q(), mixed_q(), mixed_q());
      drain();
    end

    repeat (700) @(posedge clk);
    $display("sent %0d items over 13 coefficient settings, %0d results checked, %0d saturated",
             items_sent, forces_seen, sat_seen);
    $display("covered field and register extremes, zero divisor and random stalls");
    if (fail_count == 0 && forces_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
